@@ hw/rtl/nsc_pkg.sv @@
// ----------------------------------------------------------------------------
// nsc_pkg
// Types, character codes and header tags shared by the sentence framer.
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [2:0] HDR_LEN       = 3'd5;
  localparam logic [7:0] MAX_LEN_RESET = 8'd120;
  localparam int unsigned QUEUE_DEPTH  = 4;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_DOLLAR,
    CLS_LF,
    CLS_CR,
    CLS_STAR
  } beat_cls_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_HEX_HI,
    PH_HEX_LO,
    PH_TAIL
  } phase_e;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_RMC,
    KIND_GGA
  } kind_e;

  typedef struct packed {
    beat_cls_e  cls;
    logic [7:0] ch;
    logic [3:0] hex;
  } beat_t;

  typedef struct packed {
    logic  push;
    beat_t beat;
  } q_wr_t;

  typedef struct packed {
    logic  valid;
    beat_t beat;
  } q_rd_t;

  typedef struct packed {
    logic full;
  } q_st_t;

  function automatic logic [7:0] tag_rmc(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h47; // G
      3'd1:    c = 8'h4E; // N
      3'd2:    c = 8'h52; // R
      3'd3:    c = 8'h4D; // M
      3'd4:    c = 8'h43; // C
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] tag_gga(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h47; // G
      3'd1:    c = 8'h4E; // N
      3'd2:    c = 8'h47; // G
      3'd3:    c = 8'h47; // G
      3'd4:    c = 8'h41; // A
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/nsc_if.sv @@
// ----------------------------------------------------------------------------
// nsc interfaces
// Valid/ready channels: byte stream in, sentence result out, config write.
// ----------------------------------------------------------------------------
interface nsc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] sentence_kind;
  logic       checksum_ok;
  logic [7:0] sentence_length;
  modport source (output valid, output sentence_kind, output checksum_ok,
                  output sentence_length, input ready);
  modport sink   (input valid, input sentence_kind, input checksum_ok,
                  input sentence_length, output ready);
endinterface

interface nsc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/nsc_front.sv @@
// ----------------------------------------------------------------------------
// nsc_front
// Accepts receiver bytes, classifies them and decodes the hex digit value.
// ----------------------------------------------------------------------------
module nsc_front
  import nsc_pkg::*;
(
  nsc_byte_if.sink byte_i,
  input  q_st_t    st_i,
  output q_wr_t    wr_o
);

  logic [7:0] ch;
  beat_cls_e  cls;
  logic [3:0] hex;

  assign ch           = byte_i.rx_byte;
  assign byte_i.ready = !st_i.full;
  assign wr_o         = '{push: byte_i.valid && !st_i.full,
                          beat: '{cls: cls, ch: ch, hex: hex}};

  always_comb begin
    unique case (ch)
      CH_DOLLAR: cls = CLS_DOLLAR;
      CH_LF:     cls = CLS_LF;
      CH_CR:     cls = CLS_CR;
      CH_STAR:   cls = CLS_STAR;
      default:   cls = CLS_OTHER;
    endcase
  end

  always_comb begin
    if (ch >= 8'h30 && ch <= 8'h39) begin
      hex = ch[3:0];
    end else if (ch >= 8'h41 && ch <= 8'h46) begin
      hex = 4'(ch[3:0] + 4'd9);
    end else begin
      hex = 4'd0;
    end
  end

endmodule

@@ hw/rtl/nsc_queue.sv @@
// ----------------------------------------------------------------------------
// nsc_queue
// Short FIFO of classified beats between front and back.
// ----------------------------------------------------------------------------
module nsc_queue
  import nsc_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  q_wr_t wr_i,
  input  logic  pop_i,
  output q_rd_t rd_o,
  output q_st_t st_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [AW-1:0] LAST = AW'(Depth - 1);
  localparam logic [AW:0]   FULL = (AW+1)'(Depth);

  beat_t         store_q [Depth];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [AW:0]   count_q, count_d;
  logic          do_pop;

  assign st_o.full  = (count_q == FULL);
  assign rd_o.valid = (count_q != '0);
  assign rd_o.beat  = store_q[rd_ptr_q];
  assign do_pop     = pop_i && rd_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_i.push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : AW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : AW'(rd_ptr_q + 1'b1);
    end
    case ({wr_i.push, do_pop})
      2'b10:   count_d = (AW+1)'(count_q + 1'b1);
      2'b01:   count_d = (AW+1)'(count_q - 1'b1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      store_q[wr_ptr_q] <= wr_i.beat;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_o.full |-> !wr_i.push)
    else $error("nsc_queue: push while full");

endmodule

@@ hw/rtl/nsc_back.sv @@
// ----------------------------------------------------------------------------
// nsc_back
// Sentence state machine: checksum, header match, length limit, result reg.
// ----------------------------------------------------------------------------
module nsc_back
  import nsc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  q_rd_t           rd_i,
  output logic            pop_o,
  nsc_cfg_if.sink         cfg_i,
  nsc_result_if.source    result_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] acc_q, acc_d;
  logic [7:0] rsum_q, rsum_d;
  logic [2:0] hdr_q, hdr_d;
  logic       m_rmc_q, m_rmc_d;
  logic       m_gga_q, m_gga_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] max_len_q;

  logic       res_valid_q, res_valid_d;
  kind_e      res_kind_q, res_kind_d;
  logic       res_ok_q, res_ok_d;
  logic [7:0] res_len_q, res_len_d;

  beat_t      beat;
  logic       take, over, emit;

  assign beat        = rd_i.beat;
  assign take        = rd_i.valid && (!res_valid_q || result_o.ready);
  assign pop_o       = take;
  assign over        = (cnt_q >= max_len_q);
  assign cfg_i.ready = 1'b1;

  // next state
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    rsum_d  = rsum_q;
    hdr_d   = hdr_q;
    m_rmc_d = m_rmc_q;
    m_gga_d = m_gga_q;
    cnt_d   = cnt_q;
    if (take) begin
      if (beat.cls == CLS_DOLLAR || (phase_q != PH_IDLE &&
          (over || beat.cls == CLS_LF))) begin
        phase_d = (beat.cls == CLS_DOLLAR) ? PH_BODY : PH_IDLE;
        acc_d   = '0;
        rsum_d  = '0;
        hdr_d   = '0;
        m_rmc_d = 1'b1;
        m_gga_d = 1'b1;
        cnt_d   = (beat.cls == CLS_DOLLAR) ? 8'd1 : 8'd0;
      end else if (phase_q != PH_IDLE) begin
        cnt_d = 8'(cnt_q + 1'b1);
        if (beat.cls != CLS_CR) begin
          unique case (phase_q)
            PH_BODY: begin
              if (beat.cls == CLS_STAR) begin
                phase_d = PH_HEX_HI;
              end else begin
                acc_d = acc_q ^ beat.ch;
                if (hdr_q < HDR_LEN) begin
                  if (beat.ch != tag_rmc(hdr_q)) m_rmc_d = 1'b0;
                  if (beat.ch != tag_gga(hdr_q)) m_gga_d = 1'b0;
                  hdr_d = 3'(hdr_q + 1'b1);
                end
              end
            end
            PH_HEX_HI: begin
              rsum_d  = {beat.hex, 4'd0};
              phase_d = PH_HEX_LO;
            end
            PH_HEX_LO: begin
              rsum_d  = {rsum_q[7:4], beat.hex};
              phase_d = PH_TAIL;
            end
            default: ;
          endcase
        end
      end
    end
  end

  // outputs
  always_comb begin
    emit       = take && beat.cls == CLS_LF && phase_q != PH_IDLE && !over;
    res_kind_d = res_kind_q;
    res_ok_d   = res_ok_q;
    res_len_d  = res_len_q;
    if (emit) begin
      res_valid_d = 1'b1;
      if (hdr_q == HDR_LEN && m_rmc_q) begin
        res_kind_d = KIND_RMC;
      end else if (hdr_q == HDR_LEN && m_gga_q) begin
        res_kind_d = KIND_GGA;
      end else begin
        res_kind_d = KIND_OTHER;
      end
      res_ok_d  = (phase_q == PH_TAIL) && (rsum_q == acc_q);
      res_len_d = 8'(cnt_q + 1'b1);
    end else if (result_o.ready) begin
      res_valid_d = 1'b0;
    end else begin
      res_valid_d = res_valid_q;
    end
  end

  assign result_o.valid           = res_valid_q;
  assign result_o.sentence_kind   = res_kind_q;
  assign result_o.checksum_ok     = res_ok_q;
  assign result_o.sentence_length = res_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      acc_q       <= '0;
      rsum_q      <= '0;
      hdr_q       <= '0;
      m_rmc_q     <= 1'b1;
      m_gga_q     <= 1'b1;
      cnt_q       <= '0;
      max_len_q   <= MAX_LEN_RESET;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      acc_q       <= acc_d;
      rsum_q      <= rsum_d;
      hdr_q       <= hdr_d;
      m_rmc_q     <= m_rmc_d;
      m_gga_q     <= m_gga_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      if (cfg_i.valid) begin
        max_len_q <= cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_kind_q <= res_kind_d;
    res_ok_q   <= res_ok_d;
    res_len_q  <= res_len_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !$past(res_valid_q)) |-> $past(emit))
    else $error("nsc_back: result without line feed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (acc_q == '0 && cnt_q == '0 && hdr_q == '0))
    else $error("nsc_back: idle with stale sentence state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (cnt_q != '0))
    else $error("nsc_back: open sentence with zero length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !result_o.ready) |-> !take)
    else $error("nsc_back: beat taken while result stalled");

endmodule

@@ hw/rtl/nmea_sentence_checksum_framer_top.sv @@
// ----------------------------------------------------------------------------
// nmea_sentence_checksum_framer_top
// NMEA sentence framer: checksum check and GNRMC/GNGGA header detection.
// ----------------------------------------------------------------------------
// Usage:
//   byte_i   : receiver bytes, one per beat; '$' opens a sentence.
//   result_o : one beat per line feed that closes a sentence within the
//              length limit: kind, checksum_ok, length from '$' to LF.
//   cfg_i    : writes max_line_length; always ready, write only when idle.
// Throughput: one byte per cycle sustained while a waiting result is not holding the back end.
// Path: a line feed accepted on byte_i is written into the queue, then taken
//   by the sentence state machine, which loads it into the result reg.
// Reset: limit back to 120, sentence state idle, queue and result empty.
// Stall: a waiting result holds the back end; bytes keep filling the
//   QueueDepth-entry queue and byte_i.ready drops only once it is full.
// ----------------------------------------------------------------------------
module nmea_sentence_checksum_framer_top
  import nsc_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nsc_byte_if.sink     byte_i,
  nsc_cfg_if.sink      cfg_i,
  nsc_result_if.source result_o
);

  q_wr_t wr;
  q_rd_t rd;
  q_st_t st;
  logic  pop;

  nsc_front u_front (
    .byte_i (byte_i),
    .st_i   (st),
    .wr_o   (wr)
  );

  nsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .pop_i  (pop),
    .rd_o   (rd),
    .st_o   (st)
  );

  nsc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_i     (rd),
    .pop_o    (pop),
    .cfg_i    (cfg_i),
    .result_o (result_o)
  );

endmodule
